/* rtl/msie_pkg.sv */
package msie_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_W          = 32;

    typedef enum logic [1:0] {
        FUNC_ADD_FIRST = 2'd0,
        FUNC_ADD_LATER = 2'd1,
        FUNC_CLOSE     = 2'd2,
        FUNC_EMIT      = 2'd3
    } func_t;

    // control from the sequencer to the banked store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_new;   // 1: write the new bank, 0: the running bank
        logic swap;     // close: new bank becomes the running bank
    } store_ctl_t;

endpackage

/* rtl/msie_ram.sv */
module msie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/msie_store.sv */
module msie_store
    import msie_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  store_ctl_t                      ctl,
    input  logic [$clog2(MAX_ELEMENTS)-1:0] rd_addr,
    input  logic [$clog2(MAX_ELEMENTS)-1:0] wr_addr,
    input  logic [VALUE_W-1:0]              wr_data,
    output logic [VALUE_W-1:0]              run_q,
    output logic [VALUE_W-1:0]              new_q
);

    localparam int IW = $clog2(MAX_ELEMENTS);

    // sel_reg names the physical bank that holds the running set
    logic               sel_reg;
    logic               sel_next;
    logic               wr_bank;
    logic               we0;
    logic               we1;
    logic [VALUE_W-1:0] q0;
    logic [VALUE_W-1:0] q1;

    assign sel_next = ctl.swap ? ~sel_reg : sel_reg;
    assign wr_bank  = ctl.wr_new ? ~sel_reg : sel_reg;
    assign we0      = ctl.wr_en && !wr_bank;
    assign we1      = ctl.wr_en && wr_bank;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
        end
    end

    msie_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_bank0 (
        .aclk  (aclk),
        .we    (we0),
        .waddr (wr_addr[IW-1:0]),
        .wdata (wr_data),
        .re    (ctl.rd_en),
        .raddr (rd_addr[IW-1:0]),
        .rdata (q0)
    );

    msie_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_bank1 (
        .aclk  (aclk),
        .we    (we1),
        .waddr (wr_addr[IW-1:0]),
        .wdata (wr_data),
        .re    (ctl.rd_en),
        .raddr (rd_addr[IW-1:0]),
        .rdata (q1)
    );

    assign run_q = sel_reg ? q1 : q0;
    assign new_q = sel_reg ? q0 : q1;

endmodule

/* rtl/multi_set_intersection_engine.sv */
// Channel   Ports                                        Direction
// -------   -------------------------------------------  ---------
// input     s_valid s_ready s_func s_element_value       in
// result    m_valid m_ready m_member_value m_set_empty   out
//           m_last_member
//
// One item at a time. Add to first set: scans the running set only. Add to later set:
// scans up to max(running, new count), one compare per bank per cycle.
// Close: bank swap, no copy. Emit: each result goes through the registered RAM read
// and waits for the single output register.
// Synchronous active-low reset clears state, counts, bank select and valids only.
// A stalled result holds; the next item is taken while it waits.
module multi_set_intersection_engine
    import msie_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_func,
    input  logic signed [VALUE_W-1:0] s_element_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_member_value,
    output logic                      m_set_empty,
    output logic                      m_last_member
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               hit_run_reg, hit_run_next;
    logic               hit_new_reg, hit_new_next;
    logic [CW-1:0]      run_count_reg, run_count_next;
    logic [CW-1:0]      new_count_reg, new_count_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_empty_reg, out_empty_next;
    logic               out_last_reg, out_last_next;

    store_ctl_t         ctl;
    logic [IW-1:0]      wr_addr;
    logic [VALUE_W-1:0] run_q;
    logic [VALUE_W-1:0] new_q;
    logic               accept;
    logic [CW-1:0]      limit;
    logic               issue;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // scan bound: first-set adds search the running set only
    always_comb begin
        if (func_reg == FUNC_ADD_FIRST) begin
            limit = run_count_reg;
        end else begin
            limit = (run_count_reg > new_count_reg) ? run_count_reg : new_count_reg;
        end
    end

    assign issue = (state_reg == ST_SCAN) && (k_reg < limit);

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        value_next     = value_reg;
        k_next         = k_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_run_next   = hit_run_reg;
        hit_new_next   = hit_new_reg;
        run_count_next = run_count_reg;
        new_count_next = new_count_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_value_next = out_value_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;
        ctl            = '0;
        wr_addr        = run_count_reg[IW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    func_next    = func_t'(s_func);
                    value_next   = s_element_value;
                    k_next       = '0;
                    hit_run_next = 1'b0;
                    hit_new_next = 1'b0;
                    case (func_t'(s_func))
                        FUNC_ADD_FIRST, FUNC_ADD_LATER: begin
                            state_next = ST_SCAN;
                        end
                        FUNC_CLOSE: begin
                            ctl.swap       = 1'b1;
                            run_count_next = new_count_reg;
                            new_count_next = '0;
                        end
                        default: begin
                            state_next = ST_EMIT_RD;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read index k now, compare the entry in the next cycle
                if (issue) begin
                    ctl.rd_en      = 1'b1;
                    k_next         = k_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = k_reg;
                end
                if (cmp_valid_reg) begin
                    if (cmp_idx_reg < run_count_reg && run_q == value_reg) begin
                        hit_run_next = 1'b1;
                    end
                    if (cmp_idx_reg < new_count_reg && new_q == value_reg) begin
                        hit_new_next = 1'b1;
                    end
                end
                if (!issue && !cmp_valid_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_IDLE;
                if (func_reg == FUNC_ADD_FIRST) begin
                    if (!hit_run_reg && run_count_reg < MAX_CNT) begin
                        ctl.wr_en      = 1'b1;
                        run_count_next = run_count_reg + 1'b1;
                    end
                end else begin
                    wr_addr    = new_count_reg[IW-1:0];
                    ctl.wr_new = 1'b1;
                    if (hit_run_reg && !hit_new_reg && new_count_reg < MAX_CNT) begin
                        ctl.wr_en      = 1'b1;
                        new_count_next = new_count_reg + 1'b1;
                    end
                end
            end
            ST_EMIT_RD: begin
                if (!out_valid_reg) begin
                    if (run_count_reg == '0) begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_empty_next = 1'b1;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        ctl.rd_en  = 1'b1;
                        state_next = ST_EMIT_LD;
                    end
                end
            end
            ST_EMIT_LD: begin
                out_valid_next = 1'b1;
                out_value_next = run_q;
                out_empty_next = 1'b0;
                out_last_next  = (k_reg + 1'b1 == run_count_reg);
                k_next         = k_reg + 1'b1;
                state_next     = (k_reg + 1'b1 == run_count_reg) ? ST_IDLE : ST_EMIT_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            run_count_reg <= '0;
            new_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            run_count_reg <= run_count_next;
            new_count_reg <= new_count_next;
            out_valid_reg <= out_valid_next;
        end
        func_reg      <= func_next;
        value_reg     <= value_next;
        k_reg         <= k_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_run_reg   <= hit_run_next;
        hit_new_reg   <= hit_new_next;
        out_value_reg <= out_value_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    msie_store #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .rd_addr (k_reg[IW-1:0]),
        .wr_addr (wr_addr),
        .wr_data (value_reg),
        .run_q   (run_q),
        .new_q   (new_q)
    );

    assign m_valid        = out_valid_reg;
    assign m_member_value = out_value_reg;
    assign m_set_empty    = out_empty_reg;
    assign m_last_member  = out_last_reg;

    // counts never pass capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        run_count_reg <= MAX_CNT && new_count_reg <= MAX_CNT)
        else $error("set count beyond capacity");

    // an emit load never overwrites a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT_LD |-> !out_valid_reg)
        else $error("emit load over a pending result");

    // the empty-set result is zero and closes its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_set_empty |-> m_last_member && m_member_value == '0)
        else $error("malformed empty-set result");

    // a close leaves the new set empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_func == FUNC_CLOSE |=> new_count_reg == '0)
        else $error("new set not cleared on close");

endmodule
